### hdl/adm_pkg.sv
// Shared types, character codes and error handling for the ASCII decimal parser.
`timescale 1ns / 1ps
`default_nettype none

package adm_pkg;

    // Default number of kept fraction digits (valid range 1 to 3).
    localparam int FRACTION_DIGITS_DEF = 3;

    // Largest magnitude that the signed result can carry.
    localparam logic [63:0] MAG_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

    // Width of a kept fraction at the largest digit count (at most 999).
    localparam int FRAC_W = 10;
    // Working width for multiplying a fraction by ten.
    localparam int PAD_W  = FRAC_W + 4;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_NAN       = 2'd1,
        ERR_NOT_WHOLE = 2'd2,
        ERR_OVERFLOW  = 2'd3
    } t_err;

    typedef struct packed {
        logic [7:0] character;
        logic       last_char;
        logic       require_whole;
    } t_in_beat;

    typedef struct packed {
        logic signed [63:0] value;
        t_err               error_code;
    } t_out_beat;

    // Parser state captured at the final character of a number.
    typedef struct packed {
        logic              is_negative;
        logic              require_whole;
        t_err              err;
        logic [63:0]       whole;
        logic [FRAC_W-1:0] frac;
    } t_snap;

    // Unsigned result and final error code, ahead of sign handling.
    typedef struct packed {
        logic        is_negative;
        t_err        err;
        logic [63:0] magnitude;
    } t_scaled;

    // Sticky error update: not a number wins over everything, and the
    // first other error stays.
    function automatic t_err merge_err(input t_err cur, input t_err code);
        t_err res;
        res = cur;
        if (cur != ERR_NAN) begin
            if (code == ERR_NAN || cur == ERR_NONE) begin
                res = code;
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### hdl/ascii_decimal_to_milli_fixed.sv
// Top level of the ASCII decimal to signed fixed-point parser.
//
// Input channel: one ASCII character per beat, with last_char marking the end
// of a number and require_whole (taken with the last character) asking for an
// integer result. Output channel: one beat per number, carrying the signed
// value in units of 10^-FRACTION_DIGITS (or the integer in whole mode) and an
// error code; value is zero whenever the code is nonzero.
// Throughput is one character per cycle while the snapshot stage has room
// for a final character. The result passes the input register and parser
// state update, the magnitude scaling multiply, then sign and output register.
// When the receiver stalls, characters that are not final keep flowing into
// the parser; up to three finished numbers wait in the stages before the
// input side holds off on a final character.
// Reset clears all valid flags and returns the parser to the start of a number.
`timescale 1ns / 1ps
`default_nettype none

module ascii_decimal_to_milli_fixed #(
    parameter int FRACTION_DIGITS = adm_pkg::FRACTION_DIGITS_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  wire adm_pkg::t_in_beat i_in_beat,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output adm_pkg::t_out_beat o_out_beat
);

    logic               w_snap_valid;
    logic               w_snap_ready;
    adm_pkg::t_snap     w_snap;
    logic               w_scl_valid;
    logic               w_scl_ready;
    adm_pkg::t_scaled   w_scl;

    logic               r_out_v;
    adm_pkg::t_out_beat r_out;
    adm_pkg::t_out_beat n_out;

    adm_scan #(
        .FRACTION_DIGITS(FRACTION_DIGITS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (i_in_beat),
        .o_snap_valid(w_snap_valid),
        .i_snap_ready(w_snap_ready),
        .o_snap      (w_snap)
    );

    adm_scale #(
        .FRACTION_DIGITS(FRACTION_DIGITS)
    ) u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_snap_valid(w_snap_valid),
        .o_snap_ready(w_snap_ready),
        .i_snap      (w_snap),
        .o_scl_valid (w_scl_valid),
        .i_scl_ready (w_scl_ready),
        .o_scl       (w_scl)
    );

    assign w_scl_ready = !r_out_v || i_out_ready;

    always_comb begin
        n_out.error_code = w_scl.err;
        if (w_scl.err != adm_pkg::ERR_NONE) begin
            n_out.value = '0;
        end else if (w_scl.is_negative) begin
            n_out.value = -$signed(w_scl.magnitude);
        end else begin
            n_out.value = $signed(w_scl.magnitude);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_scl_ready) begin
            r_out_v <= w_scl_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_scl_ready && w_scl_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_beat  = r_out;

    // With an empty snapshot stage the parser can always take a character.
    a_ready_when_snap_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_snap_valid |-> o_in_ready)
        else $error("input stalled with an empty snapshot stage");

    // A character that is not final never blocks the next one.
    a_mid_char_no_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !i_in_beat.last_char) |=> o_in_ready)
        else $error("input stalled behind a non-final character");

    // A new result only follows a scaled item in the stage before.
    a_out_from_scale : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_scl_valid))
        else $error("result appeared without a scaled item");

    a_reset_clears_out : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

`default_nettype wire

### hdl/adm_scan.sv
// Input register and per-character parser state; captures a snapshot on the last character.
`timescale 1ns / 1ps
`default_nettype none

module adm_scan #(
    parameter int FRACTION_DIGITS = adm_pkg::FRACTION_DIGITS_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  wire adm_pkg::t_in_beat i_in_beat,
    output logic             o_snap_valid,
    input  wire              i_snap_ready,
    output adm_pkg::t_snap   o_snap
);

    localparam int FracW    = $clog2(10 ** FRACTION_DIGITS);
    localparam int CntW     = $clog2(FRACTION_DIGITS + 1);
    localparam int FracMulW = FracW + 4;
    localparam logic [63:0] Cap = adm_pkg::MAG_LIMIT / 64'(10 ** FRACTION_DIGITS);
    localparam logic [CntW-1:0] FdCnt = CntW'(FRACTION_DIGITS);

    logic              r_in_v;
    adm_pkg::t_in_beat r_in;

    logic              r_first;
    logic              r_neg;
    logic [63:0]       r_whole;
    logic [FracW-1:0]  r_frac;
    logic [CntW-1:0]   r_cnt;
    logic              r_in_frac;
    logic              r_saw;
    adm_pkg::t_err     r_err;

    logic              n_first;
    logic              n_neg;
    logic [63:0]       n_whole;
    logic [FracW-1:0]  n_frac;
    logic [CntW-1:0]   n_cnt;
    logic              n_in_frac;
    logic              n_saw;
    adm_pkg::t_err     n_err;

    logic              r_snap_v;
    adm_pkg::t_snap    r_snap;
    adm_pkg::t_snap    n_snap;

    logic [7:0]            w_ch;
    logic [7:0]            w_dig8;
    logic [3:0]            w_digit;
    logic                  w_is_digit;
    logic [67:0]           w_whole10;
    logic [FracMulW-1:0]   w_frac_ext;
    logic [adm_pkg::PAD_W-1:0] w_pad;
    logic                  w_snap_free;
    logic                  w_consume;

    assign w_snap_free = !r_snap_v || i_snap_ready;
    // A final character needs room in the snapshot stage; others only touch state.
    assign w_consume   = r_in_v && (!r_in.last_char || w_snap_free);
    assign o_in_ready  = !r_in_v || w_consume;

    assign w_ch       = r_in.character;
    assign w_dig8     = w_ch - adm_pkg::CH_ZERO;
    assign w_digit    = w_dig8[3:0];
    assign w_is_digit = (w_ch >= adm_pkg::CH_ZERO) && (w_ch <= adm_pkg::CH_NINE);
    // whole*10 + digit, wide enough that it cannot wrap.
    assign w_whole10  = (68'(r_whole) << 3) + (68'(r_whole) << 1) + 68'(w_digit);
    assign w_frac_ext = FracMulW'(r_frac) * FracMulW'(10) + FracMulW'(w_digit);

    always_comb begin
        n_first   = 1'b0;
        n_neg     = r_neg;
        n_whole   = r_whole;
        n_frac    = r_frac;
        n_cnt     = r_cnt;
        n_in_frac = r_in_frac;
        n_saw     = r_saw;
        n_err     = r_err;
        if (w_is_digit) begin
            n_saw = 1'b1;
            if (!r_in_frac) begin
                if (r_err == adm_pkg::ERR_NONE) begin
                    if (w_whole10 > 68'(Cap)) begin
                        n_err = adm_pkg::merge_err(r_err, adm_pkg::ERR_OVERFLOW);
                    end else begin
                        n_whole = w_whole10[63:0];
                    end
                end
            end else if (r_cnt < FdCnt) begin
                n_frac = w_frac_ext[FracW-1:0];
                n_cnt  = r_cnt + CntW'(1);
            end
        end else if (w_ch == adm_pkg::CH_POINT) begin
            if (r_in_frac) begin
                n_err = adm_pkg::merge_err(r_err, adm_pkg::ERR_NAN);
            end
            n_in_frac = 1'b1;
        end else if ((w_ch == adm_pkg::CH_MINUS || w_ch == adm_pkg::CH_PLUS) && r_first) begin
            n_neg = (w_ch == adm_pkg::CH_MINUS);
        end else begin
            n_err = adm_pkg::merge_err(r_err, adm_pkg::ERR_NAN);
        end
    end

    // Scale the kept fraction up to the full number of fraction digits.
    always_comb begin
        w_pad = adm_pkg::PAD_W'(n_frac);
        for (int i = 0; i < FRACTION_DIGITS; i++) begin
            if (CntW'(i) >= n_cnt) begin
                w_pad = w_pad * adm_pkg::PAD_W'(10);
            end
        end
    end

    always_comb begin
        n_snap.is_negative   = n_neg;
        n_snap.require_whole = r_in.require_whole;
        n_snap.err           = n_saw ? n_err : adm_pkg::merge_err(n_err, adm_pkg::ERR_NAN);
        n_snap.whole         = n_whole;
        n_snap.frac          = w_pad[adm_pkg::FRAC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v    <= 1'b0;
            r_snap_v  <= 1'b0;
            r_first   <= 1'b1;
            r_neg     <= 1'b0;
            r_whole   <= '0;
            r_frac    <= '0;
            r_cnt     <= '0;
            r_in_frac <= 1'b0;
            r_saw     <= 1'b0;
            r_err     <= adm_pkg::ERR_NONE;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_v <= 1'b1;
            end else if (w_consume) begin
                r_in_v <= 1'b0;
            end
            if (w_snap_free) begin
                r_snap_v <= w_consume && r_in.last_char;
            end
            if (w_consume) begin
                if (r_in.last_char) begin
                    r_first   <= 1'b1;
                    r_neg     <= 1'b0;
                    r_whole   <= '0;
                    r_frac    <= '0;
                    r_cnt     <= '0;
                    r_in_frac <= 1'b0;
                    r_saw     <= 1'b0;
                    r_err     <= adm_pkg::ERR_NONE;
                end else begin
                    r_first   <= n_first;
                    r_neg     <= n_neg;
                    r_whole   <= n_whole;
                    r_frac    <= n_frac;
                    r_cnt     <= n_cnt;
                    r_in_frac <= n_in_frac;
                    r_saw     <= n_saw;
                    r_err     <= n_err;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_beat;
        end
        if (w_consume && r_in.last_char) begin
            r_snap <= n_snap;
        end
    end

    assign o_snap_valid = r_snap_v;
    assign o_snap       = r_snap;

endmodule

`default_nettype wire

### hdl/adm_scale.sv
// Scaling stage: forms the fixed-point magnitude and resolves overflow and whole-number errors.
`timescale 1ns / 1ps
`default_nettype none

module adm_scale #(
    parameter int FRACTION_DIGITS = adm_pkg::FRACTION_DIGITS_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_snap_valid,
    output logic             o_snap_ready,
    input  wire adm_pkg::t_snap i_snap,
    output logic             o_scl_valid,
    input  wire              i_scl_ready,
    output adm_pkg::t_scaled o_scl
);

    localparam logic [64:0] Scale = 65'(10 ** FRACTION_DIGITS);

    logic             r_scl_v;
    adm_pkg::t_scaled r_scl;
    adm_pkg::t_scaled n_scl;
    logic [64:0]      w_mag;

    assign o_snap_ready = !r_scl_v || i_scl_ready;

    // Constant multiply; the snapshot keeps whole below the limit divided by the scale.
    assign w_mag = 65'(i_snap.whole) * Scale + 65'(i_snap.frac);

    always_comb begin
        n_scl.is_negative = i_snap.is_negative;
        n_scl.err         = i_snap.err;
        if (n_scl.err == adm_pkg::ERR_NONE && w_mag > 65'(adm_pkg::MAG_LIMIT)) begin
            n_scl.err = adm_pkg::ERR_OVERFLOW;
        end
        if (n_scl.err == adm_pkg::ERR_NONE && i_snap.require_whole && i_snap.frac != '0) begin
            n_scl.err = adm_pkg::ERR_NOT_WHOLE;
        end
        n_scl.magnitude = i_snap.require_whole ? i_snap.whole : w_mag[63:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scl_v <= 1'b0;
        end else if (o_snap_ready) begin
            r_scl_v <= i_snap_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_snap_ready && i_snap_valid) begin
            r_scl <= n_scl;
        end
    end

    assign o_scl_valid = r_scl_v;
    assign o_scl       = r_scl;

endmodule

`default_nettype wire
